// ----- hdl/sua_pkg.sv -----
package sua_pkg;

	localparam int VALVE_W             = 4;
	localparam int MV_W                = 16;
	localparam int TIME_W              = 32;
	localparam int QUEUE_DEPTH         = 2;
	localparam int NUM_VALVES_DEF      = 8;
	localparam int ENABLE_AT_RESET_DEF = 1;

	localparam logic [MV_W-1:0] UNDERSHOOT_RST = 16'd200;
	localparam logic [MV_W-1:0] APPROACH_RST   = 16'd500;

	// register indexes on the configuration port
	localparam logic CFG_UNDERSHOOT = 1'b0;
	localparam logic CFG_APPROACH   = 1'b1;

	// command codes on the input channel
	localparam logic [1:0] CMD_REQUEST = 2'd0;
	localparam logic [1:0] CMD_FORCE   = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] CMD_ENABLE  = 2'd3;

	typedef enum logic [2:0] {
		OP_REQ,
		OP_FORCE,
		OP_TICK,
		OP_EN,
		OP_DIS
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [VALVE_W-1:0] valve;
		logic [MV_W-1:0]    mv;
		logic [TIME_W-1:0]  now;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

// ----- hdl/setpoint_undershoot_approach.sv -----
// Per-valve setpoint writer that settles onto a lower setpoint from below. Commands are decoded
// on entry (requests and forces for a valve out of range are dropped there) and wait in a
// two-entry queue, so the input keeps taking beats while the queue has room, also while the
// executor works or the output stalls. A request or force gives one DAC write. A tick while
// enabled, or a disable, walks the valve table one entry per cycle, but stalls while a held write
// waits for a full output register; each write it makes is held back until the next is found or
// the walk ends, so that the final write can carry the last flag. Each result sits in an output
// register until taken; a free output register lets the executor continue in the same cycle.
module setpoint_undershoot_approach import sua_pkg::*; #(
	parameter int NUM_VALVES      = NUM_VALVES_DEF,
	parameter int ENABLE_AT_RESET = ENABLE_AT_RESET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [VALVE_W-1:0] valve_index,
	input  logic [MV_W-1:0]    setpoint_mv,
	input  logic               enable_flag,
	input  logic [TIME_W-1:0]  now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALVE_W-1:0] out_valve,
	output logic [MV_W-1:0]    output_mv,
	output logic               approach_on,
	output logic               last,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [MV_W-1:0]    cfg_data
);

	logic q_ready;
	logic q_push;
	cmd_t q_data;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	sua_front #(
		.NUM_VALVES(NUM_VALVES)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.valve_index(valve_index),
		.setpoint_mv(setpoint_mv),
		.enable_flag(enable_flag),
		.now_ms     (now_ms),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	sua_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_head)
	);

	sua_back #(
		.NUM_VALVES     (NUM_VALVES),
		.ENABLE_AT_RESET(ENABLE_AT_RESET)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_valve  (out_valve),
		.output_mv  (output_mv),
		.approach_on(approach_on),
		.last       (last)
	);

endmodule

// ----- hdl/sua_front.sv -----
module sua_front import sua_pkg::*; #(
	parameter int NUM_VALVES = NUM_VALVES_DEF
) (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [VALVE_W-1:0] valve_index,
	input  logic [MV_W-1:0]    setpoint_mv,
	input  logic               enable_flag,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic               q_ready,
	output logic               q_push,
	output cmd_t               q_data
);

	logic in_range;
	logic keep;

	assign in_range = 32'(valve_index) < NUM_VALVES;
	assign in_ready = q_ready;

	always_comb begin
		q_data.valve = valve_index;
		q_data.mv    = setpoint_mv;
		q_data.now   = now_ms;
		keep         = 1'b1;
		case (command)
			CMD_REQUEST: begin
				q_data.op = OP_REQ;
				keep      = in_range;
			end
			CMD_FORCE: begin
				q_data.op = OP_FORCE;
				keep      = in_range;
			end
			CMD_TICK:   q_data.op = OP_TICK;
			default:    q_data.op = enable_flag ? OP_EN : OP_DIS;
		endcase
	end

	// requests and forces for a valve out of range are taken and dropped
	assign q_push = in_valid && q_ready && keep;

endmodule

// ----- hdl/sua_queue.sv -----
module sua_queue import sua_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/sua_back.sv -----
module sua_back import sua_pkg::*; #(
	parameter int NUM_VALVES      = NUM_VALVES_DEF,
	parameter int ENABLE_AT_RESET = ENABLE_AT_RESET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cmd_t               q_head,
	output logic               q_pop,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [MV_W-1:0]    cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALVE_W-1:0] out_valve,
	output logic [MV_W-1:0]    output_mv,
	output logic               approach_on,
	output logic               last
);

	localparam int IDX_W = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;

	logic [MV_W-1:0]   target_q   [NUM_VALVES];
	logic [MV_W-1:0]   applied_q  [NUM_VALVES];
	logic              dipping_q  [NUM_VALVES];
	logic [TIME_W-1:0] start_q    [NUM_VALVES];

	logic [MV_W-1:0]   undershoot_q;
	logic [MV_W-1:0]   approach_q;
	logic              en_q, en_d;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              scan_dis_q, scan_dis_d;
	logic [TIME_W-1:0] scan_now_q, scan_now_d;

	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [MV_W-1:0]   pend_mv_q;
	logic              pend_load, pend_clear;

	logic              out_valid_q;
	logic [VALVE_W-1:0] out_valve_q;
	logic [MV_W-1:0]   out_mv_q;
	logic              out_on_q;
	logic              out_last_q;
	logic              out_load;
	logic [VALVE_W-1:0] out_valve_d;
	logic [MV_W-1:0]   out_mv_d;
	logic              out_last_d;

	logic [IDX_W-1:0]  addr;
	logic [MV_W-1:0]   tgt_rd, app_rd;
	logic              dip_rd;
	logic [TIME_W-1:0] start_rd;
	logic [MV_W-1:0]   dip_mv;
	logic [TIME_W-1:0] elapsed;
	logic              hit;
	logic              slot_free;

	logic              wr_en, wr_dip, wr_start_en;
	logic [MV_W-1:0]   wr_tgt, wr_app;

	assign addr     = (state_q == ST_IDLE) ? q_head.valve[IDX_W-1:0] : idx_q;
	assign tgt_rd   = target_q[addr];
	assign app_rd   = applied_q[addr];
	assign dip_rd   = dipping_q[addr];
	assign start_rd = start_q[addr];

	assign dip_mv    = (q_head.mv > undershoot_q) ? q_head.mv - undershoot_q : '0;
	// wrap-safe elapsed time
	assign elapsed   = scan_now_q - start_rd;
	assign hit       = dip_rd && (scan_dis_q || elapsed >= TIME_W'(approach_q));
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		q_pop       = 1'b0;
		en_d        = en_q;
		state_d     = state_q;
		idx_d       = idx_q;
		scan_dis_d  = scan_dis_q;
		scan_now_d  = scan_now_q;
		pend_load   = 1'b0;
		pend_clear  = 1'b0;
		out_load    = 1'b0;
		out_valve_d = VALVE_W'(pend_idx_q);
		out_mv_d    = pend_mv_q;
		out_last_d  = 1'b0;
		wr_en       = 1'b0;
		wr_tgt      = tgt_rd;
		wr_app      = tgt_rd;
		wr_dip      = 1'b0;
		wr_start_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_head.op)
						OP_REQ, OP_FORCE: begin
							if (slot_free) begin
								q_pop       = 1'b1;
								wr_en       = 1'b1;
								wr_tgt      = q_head.mv;
								out_load    = 1'b1;
								out_valve_d = q_head.valve;
								out_last_d  = 1'b1;
								if (q_head.op == OP_FORCE || !en_q || q_head.mv >= app_rd) begin
									wr_app   = q_head.mv;
									out_mv_d = q_head.mv;
								end else begin
									wr_app      = dip_mv;
									wr_dip      = 1'b1;
									wr_start_en = 1'b1;
									out_mv_d    = dip_mv;
								end
							end
						end
						OP_TICK: begin
							q_pop = 1'b1;
							if (en_q) begin
								state_d    = ST_SCAN;
								idx_d      = '0;
								scan_dis_d = 1'b0;
								scan_now_d = q_head.now;
							end
						end
						OP_EN: begin
							q_pop = 1'b1;
							en_d  = 1'b1;
						end
						default: begin
							q_pop      = 1'b1;
							en_d       = 1'b0;
							state_d    = ST_SCAN;
							idx_d      = '0;
							scan_dis_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// a hit hands the held write on, so it can only go once the slot is free
				if (!hit || !pend_valid_q || slot_free) begin
					if (hit) begin
						wr_en     = 1'b1;
						pend_load = 1'b1;
						out_load  = pend_valid_q;
					end
					if (idx_q == IDX_W'(NUM_VALVES - 1)) begin
						state_d = ST_DRAIN;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					pend_clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_start_en) begin
			start_q[addr] <= q_head.now;
		end
		if (pend_load) begin
			pend_idx_q <= idx_q;
			pend_mv_q  <= tgt_rd;
		end
		if (out_load) begin
			out_valve_q <= out_valve_d;
			out_mv_q    <= out_mv_d;
			out_on_q    <= en_q;
			out_last_q  <= out_last_d;
		end
		scan_now_q <= scan_now_d;
		scan_dis_q <= scan_dis_d;
		idx_q      <= idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VALVES; i++) begin
				target_q[i]  <= '0;
				applied_q[i] <= '0;
				dipping_q[i] <= 1'b0;
			end
			undershoot_q <= UNDERSHOOT_RST;
			approach_q   <= APPROACH_RST;
			en_q         <= (ENABLE_AT_RESET != 0);
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				target_q[addr]  <= wr_tgt;
				applied_q[addr] <= wr_app;
				dipping_q[addr] <= wr_dip;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_UNDERSHOOT: undershoot_q <= cfg_data;
					CFG_APPROACH:   approach_q   <= cfg_data;
					default:        ;
				endcase
			end
			en_q    <= en_d;
			state_q <= state_d;
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_valve   = out_valve_q;
	assign output_mv   = out_mv_q;
	assign approach_on = out_on_q;
	assign last        = out_last_q;

endmodule

// ----- tb/sua_dac_checker.sv -----
module sua_dac_checker import sua_pkg::*; #(
	parameter int NUM_VALVES      = NUM_VALVES_DEF,
	parameter int ENABLE_AT_RESET = ENABLE_AT_RESET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         command,
	input  logic [VALVE_W-1:0] valve_index,
	input  logic [MV_W-1:0]    setpoint_mv,
	input  logic               enable_flag,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [VALVE_W-1:0] out_valve,
	input  logic [MV_W-1:0]    output_mv,
	input  logic               approach_on,
	input  logic               last,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [MV_W-1:0]    cfg_data,
	output int                 fail_count,
	output int                 writes_owed
);

	typedef struct packed {
		logic [VALVE_W-1:0] valve;
		logic [MV_W-1:0]    mv;
		logic               on;
		logic               last;
	} dac_write_t;

	dac_write_t dac_writes_due[$];
	dac_write_t step_writes[NUM_VALVES];
	int         step_n;

	logic [MV_W-1:0]   target[NUM_VALVES];
	logic [MV_W-1:0]   applied[NUM_VALVES];
	logic              dipping[NUM_VALVES];
	logic [TIME_W-1:0] dip_t0[NUM_VALVES];
	logic              enabled;
	logic [MV_W-1:0]   undershoot;
	logic [MV_W-1:0]   approach;

	task automatic add_write(input int v, input logic [MV_W-1:0] mv);
		step_writes[step_n].valve = VALVE_W'(v);
		step_writes[step_n].mv    = mv;
		step_writes[step_n].on    = enabled;
		step_writes[step_n].last  = 1'b0;
		step_n++;
	endtask

	task automatic restore_valve(input int v);
		dipping[v] = 1'b0;
		applied[v] = target[v];
		add_write(v, target[v]);
	endtask

	task automatic predict_dac_writes(input logic [1:0] cmd, input logic [VALVE_W-1:0] v,
			input logic [MV_W-1:0] mv, input logic flag, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		int i;
		step_n = 0;
		case (cmd)
			CMD_REQUEST, CMD_FORCE: begin
				if (int'(v) < NUM_VALVES) begin
					target[v] = mv;
					if (cmd == CMD_FORCE || !enabled || mv >= applied[v]) begin
						applied[v] = mv;
						dipping[v] = 1'b0;
						add_write(int'(v), mv);
					end else begin
						// dip below the new target, clamped at zero
						applied[v] = (mv > undershoot) ? mv - undershoot : '0;
						dipping[v] = 1'b1;
						dip_t0[v]  = now;
						add_write(int'(v), applied[v]);
					end
				end
			end
			CMD_TICK: begin
				if (enabled) begin
					for (i = 0; i < NUM_VALVES; i++) begin
						elapsed = now - dip_t0[i];
						if (dipping[i] && elapsed >= {16'd0, approach})
							restore_valve(i);
					end
				end
			end
			default: begin
				enabled = flag;
				if (!flag) begin
					for (i = 0; i < NUM_VALVES; i++)
						if (dipping[i])
							restore_valve(i);
				end
			end
		endcase
		if (step_n > 0)
			step_writes[step_n-1].last = 1'b1;
		for (i = 0; i < step_n; i++)
			dac_writes_due.push_back(step_writes[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dac_write_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < NUM_VALVES; i++) begin
				target[i]  = '0;
				applied[i] = '0;
				dipping[i] = 1'b0;
				dip_t0[i]  = '0;
			end
			enabled    = (ENABLE_AT_RESET != 0);
			undershoot = UNDERSHOOT_RST;
			approach   = APPROACH_RST;
			dac_writes_due.delete();
			fail_count  = 0;
			writes_owed = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_UNDERSHOOT)
					undershoot = cfg_data;
				else
					approach = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (dac_writes_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected beat: valve %0d mv %0d on %0b last %0b",
							out_valve, output_mv, approach_on, last);
				end else begin
					want = dac_writes_due.pop_front();
					if (out_valve !== want.valve || output_mv !== want.mv ||
							approach_on !== want.on || last !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: got valve %0d mv %0d on %0b last %0b, ",
								"expected valve %0d mv %0d on %0b last %0b"},
								out_valve, output_mv, approach_on, last,
								want.valve, want.mv, want.on, want.last);
					end
				end
			end
			if (in_valid && in_ready)
				predict_dac_writes(command, valve_index, setpoint_mv, enable_flag, now_ms);
			writes_owed = dac_writes_due.size();
		end
	end

endmodule

// ----- tb/tb_setpoint_undershoot_approach.sv -----
module tb_setpoint_undershoot_approach;
	import sua_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE      = 4 * NUM_VALVES_DEF + 16;
	localparam int PHASE_ITEMS = 56;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic [VALVE_W-1:0] valve_index;
	logic [MV_W-1:0]    setpoint_mv;
	logic               enable_flag;
	logic [TIME_W-1:0]  now_ms;
	logic               out_valid;
	logic               out_ready;
	logic [VALVE_W-1:0] out_valve;
	logic [MV_W-1:0]    output_mv;
	logic               approach_on;
	logic               last;
	logic               cfg_we;
	logic               cfg_index;
	logic [MV_W-1:0]    cfg_data;

	int                 fail_count;
	int                 writes_owed;
	int                 cycles;
	logic               steady;
	logic [TIME_W-1:0]  ms_clock;
	logic [MV_W-1:0]    approach_set;

	setpoint_undershoot_approach dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.valve_index (valve_index),
		.setpoint_mv (setpoint_mv),
		.enable_flag (enable_flag),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_valve   (out_valve),
		.output_mv   (output_mv),
		.approach_on (approach_on),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	sua_dac_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.valve_index (valve_index),
		.setpoint_mv (setpoint_mv),
		.enable_flag (enable_flag),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_valve   (out_valve),
		.output_mv   (output_mv),
		.approach_on (approach_on),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.writes_owed (writes_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: bursts of ready with stalls in between
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_ready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken, or after a random gap
	task automatic send_beat(input logic [1:0] cmd, input logic [VALVE_W-1:0] v,
			input logic [MV_W-1:0] mv, input logic flag, input logic [TIME_W-1:0] now);
		int gap;
		in_valid    = 1'b1;
		command     = cmd;
		valve_index = v;
		setpoint_mv = mv;
		enable_flag = flag;
		now_ms      = now;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (writes_owed != 0)
			@(negedge clk);
		// a tick with nothing to restore may still be scanning
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [MV_W-1:0] val);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_APPROACH)
			approach_set = val;
	endtask

	task automatic random_beat();
		int r;
		logic [1:0]         cmd;
		logic [VALVE_W-1:0] v;
		logic [MV_W-1:0]    mv;
		logic               flag;
		r = $urandom_range(0, 99);
		if (r < 45)
			cmd = CMD_REQUEST;
		else if (r < 55)
			cmd = CMD_FORCE;
		else if (r < 85)
			cmd = CMD_TICK;
		else
			cmd = CMD_ENABLE;
		v = ($urandom_range(0, 99) < 85) ? VALVE_W'($urandom_range(0, NUM_VALVES_DEF - 1))
			: VALVE_W'($urandom_range(0, 15));
		r = $urandom_range(0, 9);
		mv = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : MV_W'($urandom);
		flag = (cmd == CMD_ENABLE) ? ($urandom_range(0, 99) < 75) : 1'($urandom);
		if ($urandom_range(0, 99) < 5)
			ms_clock = $urandom;
		else
			ms_clock = ms_clock + $urandom_range(0, int'(approach_set) / 8 + 20);
		send_beat(cmd, v, mv, flag, ms_clock);
	endtask

	initial begin
		int ph;
		int k;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_REQUEST;
		valve_index  = '0;
		setpoint_mv  = '0;
		enable_flag  = 1'b0;
		now_ms       = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_UNDERSHOOT;
		cfg_data     = '0;
		steady       = 1'b0;
		ms_clock     = '0;
		approach_set = APPROACH_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(CFG_UNDERSHOOT, 16'd300);
		write_reg(CFG_APPROACH, 16'd100);
		send_beat(CMD_FORCE, 4'd0, 16'd1000, 1'b0, 32'd0);
		send_beat(CMD_REQUEST, 4'd0, 16'd5000, 1'b1, 32'd1);
		send_beat(CMD_REQUEST, 4'd0, 16'd5000, 1'b0, 32'd2);
		// lower request whose dip clamps at zero
		send_beat(CMD_REQUEST, 4'd0, 16'd100, 1'b0, 32'd10);
		send_beat(CMD_FORCE, 4'd1, 16'hFFFF, 1'b1, 32'hFFFF_FFF0);
		send_beat(CMD_REQUEST, 4'd1, 16'd0, 1'b0, 32'hFFFF_FFF0);
		send_beat(CMD_FORCE, 4'd7, 16'd40000, 1'b0, 32'hFFFF_FFF1);
		send_beat(CMD_REQUEST, 4'd7, 16'd30000, 1'b1, 32'hFFFF_FFF8);
		send_beat(CMD_TICK, 4'd0, 16'd0, 1'b0, 32'h0000_0020);
		// elapsed time crosses the 32-bit wrap
		send_beat(CMD_TICK, 4'd15, 16'hFFFF, 1'b1, 32'h0000_0054);
		send_beat(CMD_TICK, 4'd0, 16'd0, 1'b0, 32'h0000_005C);
		send_beat(CMD_TICK, 4'd0, 16'd0, 1'b0, 32'd200);
		send_beat(CMD_REQUEST, 4'd8, 16'd123, 1'b0, 32'd201);
		send_beat(CMD_FORCE, 4'd15, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_beat(CMD_FORCE, 4'd2, 16'd2000, 1'b0, 32'd300);
		send_beat(CMD_REQUEST, 4'd2, 16'd1500, 1'b0, 32'd300);
		send_beat(CMD_REQUEST, 4'd3, 16'd0, 1'b0, 32'd300);
		send_beat(CMD_ENABLE, 4'd0, 16'd0, 1'b0, 32'd301);
		// disabled: a request behaves as a force, a tick is a no-op
		send_beat(CMD_REQUEST, 4'd2, 16'd10, 1'b0, 32'd302);
		send_beat(CMD_TICK, 4'd0, 16'd0, 1'b1, 32'hFFFF_FFFF);
		send_beat(CMD_ENABLE, 4'd0, 16'd0, 1'b0, 32'd303);
		send_beat(CMD_ENABLE, 4'd0, 16'd0, 1'b1, 32'd304);
		send_beat(CMD_REQUEST, 4'd4, 16'hFFFF, 1'b0, 32'd305);

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_UNDERSHOOT, 16'hFFFF);
					write_reg(CFG_APPROACH, 16'd0);
				end
				1: begin
					write_reg(CFG_UNDERSHOOT, 16'd0);
					write_reg(CFG_APPROACH, 16'hFFFF);
				end
				2: begin
					write_reg(CFG_UNDERSHOOT, MV_W'($urandom));
					write_reg(CFG_APPROACH, MV_W'($urandom_range(1, 300)));
				end
				3: begin
					write_reg(CFG_UNDERSHOOT, UNDERSHOOT_RST);
					write_reg(CFG_APPROACH, APPROACH_RST);
				end
				default: begin
					write_reg(CFG_UNDERSHOOT, MV_W'($urandom_range(0, 2000)));
					write_reg(CFG_APPROACH, 16'd1);
				end
			endcase
			steady = (ph == 3);
			ms_clock = (ph % 2 == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000) : $urandom;
			// make sure the undershoot path is live in each phase
			send_beat(CMD_ENABLE, 4'd0, 16'd0, 1'b1, ms_clock);
			for (k = 0; k < PHASE_ITEMS; k++)
				random_beat();
		end
		steady = 1'b0;

		wait_drained();
		if (fail_count == 0 && writes_owed == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- setpoint_undershoot_approach.f -----
hdl/sua_pkg.sv
hdl/sua_front.sv
hdl/sua_queue.sv
hdl/sua_back.sv
hdl/setpoint_undershoot_approach.sv
tb/sua_dac_checker.sv
tb/tb_setpoint_undershoot_approach.sv
